// ===== sv/dlr_pkg.sv =====
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types, widths and helpers of the DDA line rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dlr_pkg;

	localparam int COORD_BITS   = 12;
	localparam int FRAC_BITS    = 16;
	localparam int ACC_BITS     = COORD_BITS + FRAC_BITS;
	localparam int INC_BITS     = FRAC_BITS + 2;
	localparam int LEFT_BITS    = COORD_BITS + 1;
	localparam int COLOR_BITS   = 32;
	localparam int QUOT_BITS    = FRAC_BITS + 1;
	localparam int DIV_CNT_BITS = $clog2(QUOT_BITS + 1);
	localparam int CMDQ_DEPTH   = 4;
	localparam int CMDQ_AW      = $clog2(CMDQ_DEPTH);
	localparam int OUTQ_DEPTH   = 2;
	localparam int OUTQ_AW      = $clog2(OUTQ_DEPTH);

	localparam logic OP_START   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	typedef struct packed {
		logic                          op;
		logic signed [COORD_BITS-1:0]  start_x;
		logic signed [COORD_BITS-1:0]  start_y;
		logic signed [COORD_BITS-1:0]  end_x;
		logic signed [COORD_BITS-1:0]  end_y;
		logic        [COLOR_BITS-1:0]  color;
	} item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0]  pixel_x;
		logic signed [COORD_BITS-1:0]  pixel_y;
		logic        [COLOR_BITS-1:0]  pixel_color;
		logic                          last;
	} pixel_t;

	typedef struct packed {
		logic                          is_start;
		logic signed [COORD_BITS-1:0]  sx;
		logic signed [COORD_BITS-1:0]  sy;
		logic        [COORD_BITS-1:0]  mag_x;
		logic        [COORD_BITS-1:0]  mag_y;
		logic                          neg_x;
		logic                          neg_y;
		logic        [COORD_BITS-1:0]  step;
		logic        [COLOR_BITS-1:0]  color;
	} cmd_t;

	// truncate a fixed-point position toward zero
	function automatic logic [COORD_BITS-1:0] trunc_pos(input logic [ACC_BITS-1:0] acc);
		logic [COORD_BITS-1:0] ip;
		logic                  rnd;
		ip  = acc[ACC_BITS-1:FRAC_BITS];
		rnd = acc[ACC_BITS-1] && (acc[FRAC_BITS-1:0] != '0);
		return ip + COORD_BITS'(rnd);
	endfunction

endpackage

// ===== sv/dlr_front.sv =====
// ----------------------------------------------------------------------------
// dlr_front
// Request intake: classifies each request, works out the line deltas, and
// queues the result for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlr_front import dlr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t item,
	output logic  cmd_valid,
	output cmd_t  cmd,
	input  logic  cmd_pop
);

	cmd_t                   cmdq_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0]     wr_ptr_q;
	logic [CMDQ_AW-1:0]     rd_ptr_q;
	logic [CMDQ_AW:0]       cnt_q;
	logic                   wr_en;
	logic                   rd_en;
	logic signed [COORD_BITS:0] dx;
	logic signed [COORD_BITS:0] dy;
	logic signed [COORD_BITS:0] ndx;
	logic signed [COORD_BITS:0] ndy;
	cmd_t                   cmd_new;

	assign full      = (cnt_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = cmdq_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_pop && cmd_valid;

	always_comb begin
		dx  = {item.end_x[COORD_BITS-1], item.end_x} - {item.start_x[COORD_BITS-1], item.start_x};
		dy  = {item.end_y[COORD_BITS-1], item.end_y} - {item.start_y[COORD_BITS-1], item.start_y};
		ndx = -dx;
		ndy = -dy;
		cmd_new.is_start = (item.op == OP_START);
		cmd_new.sx       = item.start_x;
		cmd_new.sy       = item.start_y;
		cmd_new.neg_x    = dx[COORD_BITS];
		cmd_new.neg_y    = dy[COORD_BITS];
		cmd_new.mag_x    = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
		cmd_new.mag_y    = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
		cmd_new.step     = (cmd_new.mag_x >= cmd_new.mag_y) ? cmd_new.mag_x : cmd_new.mag_y;
		cmd_new.color    = item.color;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cmdq_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (CMDQ_AW+1)'(CMDQ_DEPTH))
		else $error("command queue count out of range");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("command queue lost a request");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == cnt_q[CMDQ_AW-1:0])
		else $error("command queue pointers disagree with count");

endmodule

// ===== sv/dlr_div.sv =====
// ----------------------------------------------------------------------------
// dlr_div
// Restoring divider for both increments at once: one quotient bit per cycle,
// integer bit first, then the fraction bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlr_div import dlr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [COORD_BITS-1:0] mag_x,
	input  logic [COORD_BITS-1:0] mag_y,
	input  logic [COORD_BITS-1:0] den,
	output logic                  busy,
	output logic                  done,
	output logic [QUOT_BITS-1:0]  quot_x,
	output logic [QUOT_BITS-1:0]  quot_y
);

	logic [COORD_BITS:0]     rx_q;
	logic [COORD_BITS:0]     ry_q;
	logic [COORD_BITS-1:0]   den_q;
	logic [QUOT_BITS-1:0]    qx_q;
	logic [QUOT_BITS-1:0]    qy_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic                    ge_x;
	logic                    ge_y;
	logic [COORD_BITS:0]     tx;
	logic [COORD_BITS:0]     ty;

	assign busy   = busy_q;
	assign done   = done_q;
	assign quot_x = qx_q;
	assign quot_y = qy_q;

	always_comb begin
		ge_x = (rx_q >= {1'b0, den_q});
		ge_y = (ry_q >= {1'b0, den_q});
		tx   = ge_x ? (rx_q - {1'b0, den_q}) : rx_q;
		ty   = ge_y ? (ry_q - {1'b0, den_q}) : ry_q;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rx_q  <= {1'b0, mag_x};
			ry_q  <= {1'b0, mag_y};
			den_q <= den;
			qx_q  <= '0;
			qy_q  <= '0;
		end else if (busy_q) begin
			rx_q <= {tx[COORD_BITS-1:0], 1'b0};
			ry_q <= {ty[COORD_BITS-1:0], 1'b0};
			qx_q <= {qx_q[QUOT_BITS-2:0], ge_x};
			qy_q <= {qy_q[QUOT_BITS-2:0], ge_y};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_BITS'(1));
			if (start) begin
				cnt_q  <= DIV_CNT_BITS'(QUOT_BITS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_BITS'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q && !done_q)
		else $error("divider restarted while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held for more than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && (cnt_q == '0))
		else $error("divider done while still iterating");

endmodule

// ===== sv/dlr_back.sv =====
// ----------------------------------------------------------------------------
// dlr_back
// Line engine: latches new lines, runs the increment divider, steps the
// fixed-point position and queues pixels for the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlr_back import dlr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cmd_valid,
	input  cmd_t   cmd,
	output logic   cmd_pop,
	output logic   empty,
	input  logic   pop,
	output pixel_t pixel
);

	typedef enum logic [1:0] {
		ST_RUN = 2'b01,
		ST_DIV = 2'b10
	} back_state_t;

	back_state_t                 state_q;
	logic signed [ACC_BITS-1:0]  pos_x_q;
	logic signed [ACC_BITS-1:0]  pos_y_q;
	logic signed [INC_BITS-1:0]  inc_x_q;
	logic signed [INC_BITS-1:0]  inc_y_q;
	logic        [LEFT_BITS-1:0] left_q;
	logic        [COLOR_BITS-1:0] color_q;
	logic                        neg_x_q;
	logic                        neg_y_q;

	pixel_t                      outq_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]          owr_ptr_q;
	logic [OUTQ_AW-1:0]          ord_ptr_q;
	logic [OUTQ_AW:0]            ocnt_q;
	logic                        outq_full;
	logic                        outq_pop;

	logic                        run;
	logic                        take_start;
	logic                        emit;
	logic                        div_start;
	logic                        div_busy;
	logic                        div_done;
	logic [QUOT_BITS-1:0]        quot_x;
	logic [QUOT_BITS-1:0]        quot_y;
	logic signed [INC_BITS-1:0]  qx_ext;
	logic signed [INC_BITS-1:0]  qy_ext;
	pixel_t                      pix_new;

	assign outq_full  = (ocnt_q == (OUTQ_AW+1)'(OUTQ_DEPTH));
	assign outq_pop   = pop && !empty;
	assign empty      = (ocnt_q == '0);
	assign pixel      = outq_q[ord_ptr_q];

	assign run        = (state_q == ST_RUN) && cmd_valid;
	assign take_start = run && cmd.is_start;
	assign emit       = run && !cmd.is_start && (left_q != '0) && !outq_full;
	assign cmd_pop    = take_start || emit || (run && !cmd.is_start && (left_q == '0));
	assign div_start  = take_start && (cmd.step != '0);

	assign qx_ext     = {1'b0, quot_x};
	assign qy_ext     = {1'b0, quot_y};

	always_comb begin
		pix_new.pixel_x     = trunc_pos(pos_x_q);
		pix_new.pixel_y     = trunc_pos(pos_y_q);
		pix_new.pixel_color = color_q;
		pix_new.last        = (left_q == LEFT_BITS'(1));
	end

	dlr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag_x  (cmd.mag_x),
		.mag_y  (cmd.mag_y),
		.den    (cmd.step),
		.busy   (div_busy),
		.done   (div_done),
		.quot_x (quot_x),
		.quot_y (quot_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			pos_x_q <= '0;
			pos_y_q <= '0;
			inc_x_q <= '0;
			inc_y_q <= '0;
			left_q  <= '0;
			color_q <= '0;
			neg_x_q <= 1'b0;
			neg_y_q <= 1'b0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (take_start) begin
						pos_x_q <= {cmd.sx, {FRAC_BITS{1'b0}}};
						pos_y_q <= {cmd.sy, {FRAC_BITS{1'b0}}};
						inc_x_q <= '0;
						inc_y_q <= '0;
						left_q  <= {1'b0, cmd.step};
						color_q <= cmd.color;
						neg_x_q <= cmd.neg_x;
						neg_y_q <= cmd.neg_y;
						if (div_start) begin
							state_q <= ST_DIV;
						end
					end else if (emit) begin
						pos_x_q <= pos_x_q + {{(ACC_BITS-INC_BITS){inc_x_q[INC_BITS-1]}}, inc_x_q};
						pos_y_q <= pos_y_q + {{(ACC_BITS-INC_BITS){inc_y_q[INC_BITS-1]}}, inc_y_q};
						left_q  <= left_q - 1'b1;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						inc_x_q <= neg_x_q ? -qx_ext : qx_ext;
						inc_y_q <= neg_y_q ? -qy_ext : qy_ext;
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			outq_q[owr_ptr_q] <= pix_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_ptr_q <= '0;
			ord_ptr_q <= '0;
			ocnt_q    <= '0;
		end else begin
			if (emit) begin
				owr_ptr_q <= owr_ptr_q + 1'b1;
			end
			if (outq_pop) begin
				ord_ptr_q <= ord_ptr_q + 1'b1;
			end
			if (emit && !outq_pop) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (outq_pop && !emit) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

	a_outq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= (OUTQ_AW+1)'(OUTQ_DEPTH))
		else $error("pixel queue count out of range");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		(div_busy || div_done) |-> (state_q == ST_DIV))
		else $error("divider active outside the divide state");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && pix_new.last) |=> (left_q == '0))
		else $error("pixel count not exhausted after last pixel");

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (left_q == $past(left_q) - 1'b1))
		else $error("pixel count did not advance");

endmodule

// ===== sv/dda_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// An advance request is registered in the command queue, and its pixel in the
// pixel queue, before the pixel can be popped. Throughput: one advance request
// per cycle while neither queue is full and no divide is running.
// A start request is taken by the line engine, which then runs the one-bit-per-
// cycle increment divider when the endpoints differ; pixels wait behind it.
// Reset (arst_n low) empties both queues and clears all line state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dda_line_rasterizer import dlr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	output logic   full,
	input  item_t  item,
	output logic   empty,
	input  logic   pop,
	output pixel_t pixel
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	dlr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	dlr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.pixel     (pixel)
	);

endmodule

// ===== dv/dlr_checker.sv =====
// ----------------------------------------------------------------------------
// dlr_checker
// Watches the request and pixel channels of the DDA line rasterizer. It keeps
// its own copy of the line state, computes the pixel each accepted advance
// request of an unfinished line must produce, and compares every popped pixel field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlr_checker import dlr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  logic   full,
	input  item_t  item,
	input  logic   empty,
	input  logic   pop,
	input  pixel_t pixel,
	output int     errors,
	output int     pending
);

	longint                pos_x;
	longint                pos_y;
	longint                slope_x;
	longint                slope_y;
	longint                span_x;
	longint                span_y;
	longint                steps;
	longint                pixels_left;
	logic [COLOR_BITS-1:0] line_color;
	pixel_t                want_q[$];
	pixel_t                want;
	pixel_t                next_px;

	initial errors = 0;

	function automatic logic [COORD_BITS-1:0] whole_part(input longint acc);
		longint m;
		m = (acc < 0 ? -acc : acc) >>> FRAC_BITS;
		return COORD_BITS'(acc < 0 ? -m : m);
	endfunction

	function automatic longint slope(input longint d, input longint n);
		longint q;
		q = ((d < 0 ? -d : d) <<< FRAC_BITS) / n;
		return d < 0 ? -q : q;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x       = 0;
			pos_y       = 0;
			slope_x     = 0;
			slope_y     = 0;
			pixels_left = 0;
			line_color  = '0;
			want_q.delete();
		end else begin
			if (push && !full) begin
				if (item.op == OP_START) begin
					span_x      = longint'($signed(item.end_x)) - longint'($signed(item.start_x));
					span_y      = longint'($signed(item.end_y)) - longint'($signed(item.start_y));
					steps       = span_x < 0 ? -span_x : span_x;
					if ((span_y < 0 ? -span_y : span_y) > steps)
						steps = span_y < 0 ? -span_y : span_y;
					pos_x       = longint'($signed(item.start_x)) <<< FRAC_BITS;
					pos_y       = longint'($signed(item.start_y)) <<< FRAC_BITS;
					slope_x     = steps == 0 ? 0 : slope(span_x, steps);
					slope_y     = steps == 0 ? 0 : slope(span_y, steps);
					pixels_left = steps;
					line_color  = item.color;
				end else if (pixels_left != 0) begin
					next_px.pixel_x     = whole_part(pos_x);
					next_px.pixel_y     = whole_part(pos_y);
					next_px.pixel_color = line_color;
					next_px.last        = pixels_left == 1;
					want_q.push_back(next_px);
					pos_x       += slope_x;
					pos_y       += slope_y;
					pixels_left--;
				end
			end
			if (pop && !empty) begin
				if (want_q.size() == 0) begin
					$display("%0t ns: unexpected pixel, expected none, got %h", $time, pixel);
					errors++;
				end else begin
					want = want_q.pop_front();
					check_field("pixel_x", 32'(want.pixel_x), 32'(pixel.pixel_x));
					check_field("pixel_y", 32'(want.pixel_y), 32'(pixel.pixel_y));
					check_field("pixel_color", want.pixel_color, pixel.pixel_color);
					check_field("last", 32'(want.last), 32'(pixel.last));
				end
			end
		end
		pending = want_q.size();
	end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Top of the DDA line rasterizer bench. Drives directed corner lines, then
// random well-formed lines mixed with noise and dropped lines, over three
// phases of sender and receiver idling; the checker predicts the pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import dlr_pkg::*;

	localparam int LIMIT = 500000;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   push = 1'b0;
	logic   pop = 1'b0;
	logic   full;
	logic   empty;
	item_t  item = '0;
	pixel_t pixel;
	int     errors;
	int     pending;
	int     cycles = 0;
	int     send_idle = 28;
	int     recv_idle = 47;
	int     useful;
	int     sx, sy, ex, ey, stp, n;

	dda_line_rasterizer dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .pixel(pixel)
	);

	dlr_checker chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .pixel(pixel), .errors(errors), .pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk) begin
		pop <= $urandom_range(99) >= recv_idle;
	end

	task automatic send(input item_t req);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= req;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic start_line(input int x0, input int y0, input int x1, input int y1,
			input logic [COLOR_BITS-1:0] col);
		item_t req;
		req         = '0;
		req.op      = OP_START;
		req.start_x = COORD_BITS'(x0);
		req.start_y = COORD_BITS'(y0);
		req.end_x   = COORD_BITS'(x1);
		req.end_y   = COORD_BITS'(y1);
		req.color   = col;
		send(req);
	endtask

	task automatic advance();
		item_t req;
		req    = item_t'($bits(item_t)'({$urandom, $urandom, $urandom}));
		req.op = OP_ADVANCE;
		send(req);
	endtask

	// hold the sender until every predicted pixel has been popped
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		advance();
		start_line(0, 0, 0, 0, 32'hFFFF_FFFF);
		advance();
		start_line(-2048, -2048, 2047, 2047, 32'h0000_0000);
		repeat (2) advance();
		start_line(2047, 2047, -2048, -2048, 32'hFFFF_FFFF);
		repeat (2) advance();
		start_line(0, 0, 3, -2, 32'hA5A5_A5A5);
		repeat (4) advance();
		start_line(-1, 2, 2, -3, 32'h5A5A_5A5A);
		repeat (5) advance();
		start_line(2047, -2048, -2048, 2047, 32'h1234_5678);
		repeat (2) advance();
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = ph == 0 ? 28 : (ph == 1 ? 47 : 0);
			recv_idle = ph == 0 ? 47 : (ph == 1 ? 28 : 0);
			useful    = 0;
			while (useful < 245) begin
				if ($urandom_range(99) < 10) begin
					send(item_t'($bits(item_t)'({$urandom, $urandom, $urandom})));
					useful++;
				end else begin
					sx = $urandom_range(4095) - 2048;
					sy = $urandom_range(4095) - 2048;
					if ($urandom_range(9) == 0) begin
						ex = $urandom_range(4095) - 2048;
						ey = $urandom_range(4095) - 2048;
					end else begin
						ex = sx + $urandom_range(24) - 12;
						ey = sy + $urandom_range(24) - 12;
						ex = ex > 2047 ? 2047 : (ex < -2048 ? -2048 : ex);
						ey = ey > 2047 ? 2047 : (ey < -2048 ? -2048 : ey);
					end
					stp = ex > sx ? ex - sx : sx - ex;
					if ((ey > sy ? ey - sy : sy - ey) > stp)
						stp = ey > sy ? ey - sy : sy - ey;
					if (stp > 24)
						n = $urandom_range(8, 1);
					else
						case ($urandom_range(9))
							0: n = stp / 2;
							1: n = stp + 2;
							default: n = stp;
						endcase
					start_line(sx, sy, ex, ey, $urandom);
					repeat (n) advance();
					useful += 1 + (n < stp ? n : stp);
				end
			end
			drain();
		end

		repeat (40) @(negedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
